// ===== rtl/ttb_pkg.sv =====
// Shared types and constants for the triangle tangent basis block.
package ttb_pkg;

   localparam int IdxW   = 32;
   localparam int CoordW = 32;
   localparam int DeltaW = 33;
   localparam int ProdW  = 66;
   localparam int CompW  = 67;
   localparam int OutW   = 16;
   localparam int MagW   = 30;
   localparam int SumW   = 62;
   localparam int LenW   = 31;
   localparam int QuoW   = 15;
   localparam logic [QuoW-1:0] UnitOne = QuoW'(16384);

   // one triangle as handed from the front to the back part
   typedef struct packed {
      logic [IdxW-1:0]          idx0;
      logic [IdxW-1:0]          idx1;
      logic [IdxW-1:0]          idx2;
      logic signed [DeltaW-1:0] e1x, e1y, e1z;
      logic signed [DeltaW-1:0] e2x, e2y, e2z;
      logic signed [DeltaW-1:0] du1, dv1, du2, dv2;
   } tri_type;

   // one result item
   typedef struct packed {
      logic [IdxW-1:0]        corner_index;
      logic signed [OutW-1:0] tangent_x, tangent_y, tangent_z;
      logic signed [OutW-1:0] bitangent_x, bitangent_y, bitangent_z;
      logic                   degenerate;
      logic                   last_of_triangle;
   } rsp_type;

endpackage

// ===== rtl/ttb_front.sv =====
// Front part: holds the first two corners and forms the edge and UV deltas.
module ttb_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [191:0]         req_tdata,
   output logic                 tri_valid,
   input  logic                 tri_ready,
   output ttb_pkg::tri_type     tri_data
);
   import ttb_pkg::*;

   logic [1:0]               count_ff, count_in;
   logic [IdxW-1:0]          idx_ff [2];
   logic signed [CoordW-1:0] pos_ff [6];
   logic signed [CoordW-1:0] tex_ff [4];
   logic                     valid_ff, valid_in;
   tri_type                  tri_ff;
   logic                     acc;
   logic signed [CoordW-1:0] px, py, pz, tu, tv;

   assign px = req_tdata[63:32];
   assign py = req_tdata[95:64];
   assign pz = req_tdata[127:96];
   assign tu = req_tdata[159:128];
   assign tv = req_tdata[191:160];

   assign req_tready = !valid_ff || tri_ready;
   assign acc = req_tvalid && req_tready;
   assign tri_valid = valid_ff;
   assign tri_data  = tri_ff;

   // advance corner count; post a triangle on the third corner
   always_comb begin
      count_in = count_ff;
      valid_in = valid_ff && !tri_ready;
      if (acc) begin
         if (count_ff == 2'd2) begin
            count_in = 2'd0;
            valid_in = 1'b1;
         end else begin
            count_in = count_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         valid_ff <= valid_in;
      end
   end

   // hold corners and form deltas
   always_ff @(posedge clock) begin
      if (acc) begin
         if (count_ff == 2'd0) begin
            idx_ff[0] <= req_tdata[31:0];
            pos_ff[0] <= px; pos_ff[1] <= py; pos_ff[2] <= pz;
            tex_ff[0] <= tu; tex_ff[1] <= tv;
         end else if (count_ff == 2'd1) begin
            idx_ff[1] <= req_tdata[31:0];
            pos_ff[3] <= px; pos_ff[4] <= py; pos_ff[5] <= pz;
            tex_ff[2] <= tu; tex_ff[3] <= tv;
         end else begin
            tri_ff.idx0 <= idx_ff[0];
            tri_ff.idx1 <= idx_ff[1];
            tri_ff.idx2 <= req_tdata[31:0];
            tri_ff.e1x <= DeltaW'(pos_ff[3]) - DeltaW'(pos_ff[0]);
            tri_ff.e1y <= DeltaW'(pos_ff[4]) - DeltaW'(pos_ff[1]);
            tri_ff.e1z <= DeltaW'(pos_ff[5]) - DeltaW'(pos_ff[2]);
            tri_ff.e2x <= DeltaW'(px) - DeltaW'(pos_ff[0]);
            tri_ff.e2y <= DeltaW'(py) - DeltaW'(pos_ff[1]);
            tri_ff.e2z <= DeltaW'(pz) - DeltaW'(pos_ff[2]);
            tri_ff.du1 <= DeltaW'(tex_ff[2]) - DeltaW'(tex_ff[0]);
            tri_ff.dv1 <= DeltaW'(tex_ff[3]) - DeltaW'(tex_ff[1]);
            tri_ff.du2 <= DeltaW'(tu) - DeltaW'(tex_ff[0]);
            tri_ff.dv2 <= DeltaW'(tv) - DeltaW'(tex_ff[1]);
         end
      end
   end
endmodule

// ===== rtl/ttb_queue.sv =====
// Two-entry queue between the front and back parts.
module ttb_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  ttb_pkg::tri_type in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output ttb_pkg::tri_type out_data
);
   import ttb_pkg::*;

   tri_type    mem_ff [2];
   logic       wr_ff, rd_ff;
   logic [1:0] cnt_ff;
   logic       push, pop;

   assign in_ready  = cnt_ff != 2'd2;
   assign out_valid = cnt_ff != 2'd0;
   assign out_data  = mem_ff[rd_ff];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= 1'b0; rd_ff <= 1'b0; cnt_ff <= 2'd0;
      end else begin
         if (push) wr_ff <= !wr_ff;
         if (pop) rd_ff <= !rd_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= in_data;
   end
endmodule

// ===== rtl/ttb_back.sv =====
// Back part: cross products, one shared normalizer, three result items.
module ttb_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             tri_valid,
   output logic             tri_ready,
   input  ttb_pkg::tri_type tri_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ttb_pkg::rsp_type rsp_data
);
   import ttb_pkg::*;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_MUL  = 4'd1;
   localparam logic [3:0] S_SUM  = 4'd2;
   localparam logic [3:0] S_NORM = 4'd3;
   localparam logic [3:0] S_SHF  = 4'd4;
   localparam logic [3:0] S_SQ   = 4'd5;
   localparam logic [3:0] S_SQRT = 4'd6;
   localparam logic [3:0] S_DIV  = 4'd7;
   localparam logic [3:0] S_NEXT = 4'd8;
   localparam logic [3:0] S_OUT  = 4'd9;

   logic [3:0]  st_ff;
   tri_type     t_ff;
   logic [3:0]  step_ff;           // multiply index, 0..13
   logic signed [ProdW-1:0] prod_ff [14];
   logic signed [ProdW-1:0] pa, pb; // live multiply
   logic signed [ProdW-1:0] mul_res;
   logic signed [CompW-1:0] vec_ff [6]; // tangent xyz, bitangent xyz
   logic        vsel_ff;           // 0 tangent, 1 bitangent
   logic [CompW-1:0] mag_ff [3];
   logic        neg_ff [3];
   logic [6:0]  nbits_ff;
   logic [MagW-1:0] v_ff [3];
   logic [1:0]  ci_ff;             // component under work
   logic [SumW-1:0] sum_ff;
   logic [SumW-1:0] rem_ff;
   logic [LenW-1:0] root_ff;
   logic [4:0]  sqi_ff;
   logic [MagW+15-1:0] num_ff;
   logic [QuoW+1:0] quo_ff;
   logic [LenW:0]  drem_ff;
   logic [5:0]  dvi_ff;
   logic signed [OutW-1:0] res_ff [6];
   logic        degen_ff;
   logic [1:0]  oc_ff;
   logic        ovalid_ff;
   rsp_type     out_ff;

   assign tri_ready = st_ff == S_IDLE;
   assign rsp_valid = ovalid_ff;
   assign rsp_data  = out_ff;

   // operand select for the 14 products
   always_comb begin
      pa = '0; pb = '0;
      unique case (step_ff)
         4'd0:  begin pa = ProdW'(t_ff.du1); pb = ProdW'(t_ff.dv2); end
         4'd1:  begin pa = ProdW'(t_ff.du2); pb = ProdW'(t_ff.dv1); end
         4'd2:  begin pa = ProdW'(t_ff.dv2); pb = ProdW'(t_ff.e1x); end
         4'd3:  begin pa = ProdW'(t_ff.dv1); pb = ProdW'(t_ff.e2x); end
         4'd4:  begin pa = ProdW'(t_ff.dv2); pb = ProdW'(t_ff.e1y); end
         4'd5:  begin pa = ProdW'(t_ff.dv1); pb = ProdW'(t_ff.e2y); end
         4'd6:  begin pa = ProdW'(t_ff.dv2); pb = ProdW'(t_ff.e1z); end
         4'd7:  begin pa = ProdW'(t_ff.dv1); pb = ProdW'(t_ff.e2z); end
         4'd8:  begin pa = ProdW'(t_ff.du1); pb = ProdW'(t_ff.e2x); end
         4'd9:  begin pa = ProdW'(t_ff.du2); pb = ProdW'(t_ff.e1x); end
         4'd10: begin pa = ProdW'(t_ff.du1); pb = ProdW'(t_ff.e2y); end
         4'd11: begin pa = ProdW'(t_ff.du2); pb = ProdW'(t_ff.e1y); end
         4'd12: begin pa = ProdW'(t_ff.du1); pb = ProdW'(t_ff.e2z); end
         4'd13: begin pa = ProdW'(t_ff.du2); pb = ProdW'(t_ff.e1z); end
         default: begin pa = '0; pb = '0; end
      endcase
   end
   assign mul_res = pa * pb;

   // helpers for the normalizer
   function automatic logic [6:0] blen(input logic [CompW-1:0] x);
      logic [6:0] n;
      n = '0;
      for (int i = 0; i < CompW; i++) if (x[i]) n = 7'(i + 1);
      return n;
   endfunction

   logic [CompW-1:0] cur_mag;
   logic [6:0]  nb0;
   logic [MagW-1:0] shv;
   logic [SumW:0] trial;
   assign cur_mag = mag_ff[ci_ff];
   always_comb begin
      nb0 = blen(mag_ff[0] | mag_ff[1] | mag_ff[2]);
      if (nbits_ff > 7'd30) shv = MagW'(cur_mag >> (nbits_ff - 7'd30));
      else shv = MagW'(cur_mag << (7'd30 - nbits_ff));
      trial  = {1'b0, rem_ff} - ((SumW+1)'({root_ff, 2'b01}) << {sqi_ff, 1'b0});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
         ovalid_ff <= 1'b0;
      end else begin
         if (ovalid_ff && rsp_ready && st_ff != S_OUT) ovalid_ff <= 1'b0;
         unique case (st_ff)
            S_IDLE: if (tri_valid) begin
               t_ff <= tri_data; step_ff <= '0; st_ff <= S_MUL;
            end
            // one multiply a cycle, registered
            S_MUL: begin
               prod_ff[step_ff] <= mul_res;
               if (step_ff == 4'd13) st_ff <= S_SUM;
               else step_ff <= step_ff + 4'd1;
            end
            S_SUM: begin
               logic signed [CompW-1:0] d;
               d = CompW'(prod_ff[0]) - CompW'(prod_ff[1]);
               for (int i = 0; i < 3; i++) begin
                  vec_ff[i] <= d[CompW-1]
                     ? CompW'(prod_ff[3+2*i]) - CompW'(prod_ff[2+2*i])
                     : CompW'(prod_ff[2+2*i]) - CompW'(prod_ff[3+2*i]);
                  vec_ff[3+i] <= d[CompW-1]
                     ? CompW'(prod_ff[9+2*i]) - CompW'(prod_ff[8+2*i])
                     : CompW'(prod_ff[8+2*i]) - CompW'(prod_ff[9+2*i]);
               end
               vsel_ff <= 1'b0;
               degen_ff <= d == '0;
               st_ff <= (d == '0) ? S_NEXT : S_NORM;
            end
            // magnitudes and signs of the selected vector
            S_NORM: begin
               for (int i = 0; i < 3; i++) begin
                  logic signed [CompW-1:0] c;
                  c = vsel_ff ? vec_ff[3+i] : vec_ff[i];
                  neg_ff[i] <= c[CompW-1];
                  mag_ff[i] <= c[CompW-1] ? CompW'(-c) : c;
               end
               ci_ff <= '0; sum_ff <= '0;
               st_ff <= S_SHF;
            end
            S_SHF: begin
               nbits_ff <= nb0;
               if (nb0 == '0) begin
                  degen_ff <= 1'b1; st_ff <= S_NEXT;
               end else st_ff <= S_SQ;
            end
            // shift and square one component a cycle
            S_SQ: begin
               v_ff[ci_ff] <= shv;
               sum_ff <= sum_ff + SumW'(shv) * SumW'(shv);
               if (ci_ff == 2'd2) begin
                  st_ff <= S_SQRT; sqi_ff <= 5'd30;
                  rem_ff <= sum_ff + SumW'(shv) * SumW'(shv); root_ff <= '0;
               end else ci_ff <= ci_ff + 2'd1;
            end
            // restoring square root, one bit a cycle
            S_SQRT: begin
               if (!trial[SumW]) begin
                  rem_ff <= trial[SumW-1:0];
                  root_ff <= {root_ff[LenW-2:0], 1'b1};
               end else root_ff <= {root_ff[LenW-2:0], 1'b0};
               if (sqi_ff == '0) begin
                  ci_ff <= '0; st_ff <= S_DIV; dvi_ff <= '0;
               end else sqi_ff <= sqi_ff - 5'd1;
            end
            // rounded divide, one quotient bit a cycle
            S_DIV: begin
               if (root_ff == '0) begin
                  degen_ff <= 1'b1; st_ff <= S_NEXT;
               end else if (dvi_ff == '0) begin
                  num_ff <= {v_ff[ci_ff], 14'd0} + (MagW+15)'(root_ff >> 1);
                  drem_ff <= '0; quo_ff <= '0; dvi_ff <= 6'd1;
               end else begin
                  logic [LenW:0] r2;
                  logic [LenW:0] dt;
                  r2 = {drem_ff[LenW-1:0], num_ff[MagW+14]};
                  dt = r2 - (LenW+1)'(root_ff);
                  num_ff <= num_ff << 1;
                  if (!dt[LenW]) begin
                     drem_ff <= dt; quo_ff <= {quo_ff[QuoW:0], 1'b1};
                  end else begin
                     drem_ff <= r2; quo_ff <= {quo_ff[QuoW:0], 1'b0};
                  end
                  if (dvi_ff == 6'(MagW + 15)) begin
                     logic [QuoW+1:0] q;
                     logic [QuoW-1:0] qc;
                     q = {quo_ff[QuoW:0], !dt[LenW]};
                     qc = (q > (QuoW+2)'(UnitOne)) ? UnitOne : q[QuoW-1:0];
                     res_ff[{1'b0, ci_ff} + (vsel_ff ? 3'd3 : 3'd0)] <=
                        neg_ff[ci_ff] ? -OutW'(qc) : OutW'(qc);
                     dvi_ff <= '0;
                     if (ci_ff == 2'd2) st_ff <= S_NEXT;
                     else ci_ff <= ci_ff + 2'd1;
                  end else dvi_ff <= dvi_ff + 6'd1;
               end
            end
            S_NEXT: begin
               if (!degen_ff && !vsel_ff) begin
                  vsel_ff <= 1'b1; st_ff <= S_NORM;
               end else begin
                  oc_ff <= '0; st_ff <= S_OUT;
               end
            end
            // emit three result items
            S_OUT: if (!ovalid_ff || rsp_ready) begin
               ovalid_ff <= 1'b1;
               out_ff.corner_index <= (oc_ff == 2'd0) ? t_ff.idx0 :
                                      (oc_ff == 2'd1) ? t_ff.idx1 : t_ff.idx2;
               out_ff.tangent_x   <= degen_ff ? '0 : res_ff[0];
               out_ff.tangent_y   <= degen_ff ? '0 : res_ff[1];
               out_ff.tangent_z   <= degen_ff ? '0 : res_ff[2];
               out_ff.bitangent_x <= degen_ff ? '0 : res_ff[3];
               out_ff.bitangent_y <= degen_ff ? '0 : res_ff[4];
               out_ff.bitangent_z <= degen_ff ? '0 : res_ff[5];
               out_ff.degenerate  <= degen_ff;
               out_ff.last_of_triangle <= oc_ff == 2'd2;
               if (oc_ff == 2'd2) st_ff <= S_IDLE;
               else oc_ff <= oc_ff + 2'd1;
            end
            default: st_ff <= S_IDLE;
         endcase
      end
   end
endmodule

// ===== rtl/triangle_tangent_basis_core.sv =====
// Top level of the triangle tangent basis block.
// Vertices enter one item a cycle, except while the front stage holds a posted
// triangle that the full queue cannot take, into a front stage that holds the
// first two corners; the third corner posts a triangle into a two-entry queue.
// A back engine takes one triangle at a time: 14 products on one shared 33x33
// multiplier, then per vector a square root and three divides on one shared
// normalizer, then three result items, the last one marked; a zero determinant
// skips the normalizer. The front and queue take up to three more triangles
// while the back engine is busy or stalled.
module triangle_tangent_basis_core (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [191:0] req_tdata,   // vertex_index, pos_x, pos_y, pos_z, tex_u, tex_v
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [135:0] rsp_tdata,   // corner_index, tangent_x/y/z, bitangent_x/y/z,
                                     // degenerate, then zero fill
   output logic         rsp_tlast    // last_of_triangle
);
   import ttb_pkg::*;

   logic    f_valid, f_ready, b_valid, b_ready;
   tri_type f_data, b_data;
   rsp_type r;

   ttb_front u_front (.clock, .reset, .req_tvalid, .req_tready, .req_tdata,
      .tri_valid(f_valid), .tri_ready(f_ready), .tri_data(f_data));
   ttb_queue u_queue (.clock, .reset, .in_valid(f_valid), .in_ready(f_ready),
      .in_data(f_data), .out_valid(b_valid), .out_ready(b_ready), .out_data(b_data));
   ttb_back u_back (.clock, .reset, .tri_valid(b_valid), .tri_ready(b_ready),
      .tri_data(b_data), .rsp_valid(rsp_tvalid), .rsp_ready(rsp_tready),
      .rsp_data(r));

   assign rsp_tdata = {7'd0, r.degenerate, r.bitangent_z, r.bitangent_y,
                       r.bitangent_x, r.tangent_z, r.tangent_y, r.tangent_x,
                       r.corner_index};
   assign rsp_tlast = r.last_of_triangle;
endmodule

// ===== rtl/ttb_checker.sv =====
// Port-level checker for the triangle tangent basis block, with its bind.
module ttb_checker (
   input logic         clock,
   input logic         reset,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [135:0] rsp_tdata,
   input logic         rsp_tlast
);
   // a stalled item holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result changed while stalled");
   // degenerate results carry zero vectors
   a_degen: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[128] |-> rsp_tdata[127:32] == '0)
      else $error("degenerate result with nonzero vector");
   // tangent x stays within unit range
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> $signed(rsp_tdata[47:32]) <= 16384 &&
                     $signed(rsp_tdata[47:32]) >= -16384)
      else $error("tangent out of range");
endmodule

bind triangle_tangent_basis_core ttb_checker u_ttb_checker (.*);

// ===== test/testbench.sv =====
// Self-checking testbench for the triangle tangent basis block.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import ttb_pkg::*;

   localparam int CycleLimit = 2000000;
   localparam int DrainCycles = 300;
   localparam int HoldOffLen = 3000;
   localparam logic [31:0] MaxPos = 32'h7fff_ffff;
   localparam logic [31:0] MinNeg = 32'h8000_0000;

   typedef struct packed {
      logic [31:0] vertex_index;
      logic [31:0] pos_x, pos_y, pos_z;
      logic [31:0] tex_u, tex_v;
   } vertex_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [191:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [135:0] rsp_tdata;
   logic         rsp_tlast;

   // expected result items, oldest first
   rsp_type basis_queue[$];
   int      error_count = 0;
   int      result_count = 0;
   int      degenerate_count = 0;
   int      vertex_count = 0;
   int      cycle_count = 0;
   int      send_idle_pct = 0;
   int      recv_stall_pct = 0;
   int      hold_off_req = 0;
   int      hold_off_ack = 0;
   int      hold_off_cycles = 0;

   // predictor copy of the corner store
   int unsigned   corner_seen = 0;
   longint        held_pos[6];
   longint        held_tex[4];
   logic [31:0]   held_idx[2];

   triangle_tangent_basis_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // receiver: long hold-off on request, else random stalls
   always @(posedge clock) begin
      if (hold_off_req != hold_off_ack) begin
         hold_off_ack <= hold_off_req;
         hold_off_cycles <= HoldOffLen;
         rsp_tready <= 1'b0;
      end else if (hold_off_cycles > 0) begin
         rsp_tready <= 1'b0;
         hold_off_cycles <= hold_off_cycles - 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // exact signed product of two deltas
   function automatic logic signed [127:0] wide_mul(input longint a, input longint b);
      logic signed [127:0] x, y;
      x = a;
      y = b;
      return x * y;
   endfunction

   function automatic longint unsigned int_sqrt(input longint unsigned s);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > s) b = b >> 2;
      while (b != 0) begin
         if (s >= r + b) begin
            s = s - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // scale a vector to unit length in Q1.14; returns 0 for a zero vector
   function automatic bit unit_scale(input logic [2:0][127:0] c,
                                     output logic [2:0][15:0] r);
      logic [127:0]    m[3];
      bit              neg[3];
      longint unsigned v[3], sum, len, q;
      int              n, b;
      n = 0;
      sum = 0;
      r = '0;
      for (int i = 0; i < 3; i++) begin
         neg[i] = c[i][127];
         m[i] = neg[i] ? -c[i] : c[i];
         b = 0;
         for (int k = 0; k < 128; k++) if (m[i][k]) b = k + 1;
         if (b > n) n = b;
      end
      if (n == 0) return 1'b0;
      for (int i = 0; i < 3; i++) begin
         if (n > 30) v[i] = 64'(m[i] >> (n - 30));
         else v[i] = 64'(m[i] << (30 - n));
         v[i] = v[i] & 64'h3fff_ffff;
         sum = sum + v[i] * v[i];
      end
      len = int_sqrt(sum);
      if (len == 0) return 1'b0;
      for (int i = 0; i < 3; i++) begin
         q = (v[i] * 16384 + len / 2) / len;
         if (q > 16384) q = 16384;
         r[i] = neg[i] ? -16'(q) : 16'(q);
      end
      return 1'b1;
   endfunction

   // hold a corner or, on the third, queue the three basis items
   task automatic predict_corner(input vertex_type vx);
      longint              p[3], t[2], e1[3], e2[3];
      longint              du1, dv1, du2, dv2;
      logic signed [127:0] det;
      logic [2:0][127:0]   tan_v, bit_v;
      logic [2:0][15:0]    tan_r, bit_r;
      logic [31:0]         idx[3];
      bit                  degen;
      rsp_type             item;
      p[0] = $signed(vx.pos_x);
      p[1] = $signed(vx.pos_y);
      p[2] = $signed(vx.pos_z);
      t[0] = $signed(vx.tex_u);
      t[1] = $signed(vx.tex_v);
      if (corner_seen < 2) begin
         for (int i = 0; i < 3; i++) held_pos[corner_seen * 3 + i] = p[i];
         held_tex[corner_seen * 2] = t[0];
         held_tex[corner_seen * 2 + 1] = t[1];
         held_idx[corner_seen] = vx.vertex_index;
         corner_seen++;
         return;
      end
      corner_seen = 0;
      for (int i = 0; i < 3; i++) begin
         e1[i] = held_pos[3 + i] - held_pos[i];
         e2[i] = p[i] - held_pos[i];
      end
      du1 = held_tex[2] - held_tex[0];
      dv1 = held_tex[3] - held_tex[1];
      du2 = t[0] - held_tex[0];
      dv2 = t[1] - held_tex[1];
      det = wide_mul(du1, dv2) - wide_mul(du2, dv1);
      for (int i = 0; i < 3; i++) begin
         tan_v[i] = wide_mul(dv2, e1[i]) - wide_mul(dv1, e2[i]);
         bit_v[i] = wide_mul(du1, e2[i]) - wide_mul(du2, e1[i]);
         if (det < 0) begin
            tan_v[i] = -tan_v[i];
            bit_v[i] = -bit_v[i];
         end
      end
      degen = (det == 0);
      if (!degen) degen = !unit_scale(tan_v, tan_r);
      if (!degen) degen = !unit_scale(bit_v, bit_r);
      if (degen) begin
         tan_r = '0;
         bit_r = '0;
      end
      idx[0] = held_idx[0];
      idx[1] = held_idx[1];
      idx[2] = vx.vertex_index;
      for (int k = 0; k < 3; k++) begin
         item.corner_index = idx[k];
         item.tangent_x = tan_r[0];
         item.tangent_y = tan_r[1];
         item.tangent_z = tan_r[2];
         item.bitangent_x = bit_r[0];
         item.bitangent_y = bit_r[1];
         item.bitangent_z = bit_r[2];
         item.degenerate = degen;
         item.last_of_triangle = (k == 2);
         basis_queue.push_back(item);
      end
   endtask

   // check each accepted result item against the oldest expectation
   always @(posedge clock) begin
      rsp_type exp_item;
      if (!reset && rsp_tvalid && rsp_tready) begin
         result_count++;
         if (basis_queue.size() == 0) begin
            $error("result item with nothing expected: tdata %h", rsp_tdata);
            error_count++;
         end else begin
            exp_item = basis_queue.pop_front();
            if (exp_item.degenerate) degenerate_count++;
            if (rsp_tdata[31:0] !== exp_item.corner_index) begin
               $error("corner_index exp %h got %h", exp_item.corner_index, rsp_tdata[31:0]);
               error_count++;
            end
            if (rsp_tdata[47:32] !== exp_item.tangent_x) begin
               $error("tangent_x exp %h got %h", exp_item.tangent_x, rsp_tdata[47:32]);
               error_count++;
            end
            if (rsp_tdata[63:48] !== exp_item.tangent_y) begin
               $error("tangent_y exp %h got %h", exp_item.tangent_y, rsp_tdata[63:48]);
               error_count++;
            end
            if (rsp_tdata[79:64] !== exp_item.tangent_z) begin
               $error("tangent_z exp %h got %h", exp_item.tangent_z, rsp_tdata[79:64]);
               error_count++;
            end
            if (rsp_tdata[95:80] !== exp_item.bitangent_x) begin
               $error("bitangent_x exp %h got %h", exp_item.bitangent_x, rsp_tdata[95:80]);
               error_count++;
            end
            if (rsp_tdata[111:96] !== exp_item.bitangent_y) begin
               $error("bitangent_y exp %h got %h", exp_item.bitangent_y, rsp_tdata[111:96]);
               error_count++;
            end
            if (rsp_tdata[127:112] !== exp_item.bitangent_z) begin
               $error("bitangent_z exp %h got %h", exp_item.bitangent_z,
                      rsp_tdata[127:112]);
               error_count++;
            end
            if (rsp_tdata[128] !== exp_item.degenerate) begin
               $error("degenerate exp %0d got %0d", exp_item.degenerate, rsp_tdata[128]);
               error_count++;
            end
            if (rsp_tlast !== exp_item.last_of_triangle) begin
               $error("last_of_triangle exp %0d got %0d", exp_item.last_of_triangle,
                      rsp_tlast);
               error_count++;
            end
         end
      end
   end

   // offer one vertex item, idling first at random, and hold until taken
   task automatic send_vertex(input vertex_type vx);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {vx.tex_v, vx.tex_u, vx.pos_z, vx.pos_y, vx.pos_x, vx.vertex_index};
      @(posedge clock iff req_tready);
      predict_corner(vx);
      vertex_count++;
   endtask

   task automatic go_idle_until_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (basis_queue.size() != 0) @(posedge clock);
   endtask

   task automatic send_corner(input logic [31:0] id, input logic [31:0] x, input logic [31:0] y,
                              input logic [31:0] z, input logic [31:0] u,
                              input logic [31:0] v);
      vertex_type vx;
      vx = '{id, x, y, z, u, v};
      send_vertex(vx);
   endtask

   // coordinate: mostly modest values, some full range, some extremes
   function automatic logic [31:0] rand_coord();
      int unsigned pick;
      pick = $urandom_range(9);
      if (pick < 5) return 32'($signed($urandom_range(8 << 16)) - (4 << 16));
      if (pick < 8) return $urandom;
      if (pick == 8) return $urandom_range(1) ? MaxPos : MinNeg;
      return 32'($signed($urandom_range(6)) - 3);
   endfunction

   // one triangle with random content; some are made degenerate on purpose
   task automatic send_random_triangle();
      vertex_type c[3];
      int unsigned kind;
      kind = $urandom_range(19);
      for (int k = 0; k < 3; k++) begin
         c[k].vertex_index = $urandom;
         c[k].pos_x = rand_coord();
         c[k].pos_y = rand_coord();
         c[k].pos_z = rand_coord();
         c[k].tex_u = rand_coord();
         c[k].tex_v = rand_coord();
      end
      if (kind == 0) c[2].tex_u = c[0].tex_u;         // collapse the UV area
      if (kind == 0) c[2].tex_v = c[0].tex_v;
      if (kind == 1) c[1] = '{c[1].vertex_index, c[0].pos_x, c[0].pos_y, c[0].pos_z,
                              c[1].tex_u, c[1].tex_v};
      if (kind == 1) c[2] = '{c[2].vertex_index, c[0].pos_x, c[0].pos_y, c[0].pos_z,
                              c[2].tex_u, c[2].tex_v};
      if (kind == 2) c[2].vertex_index = c[0].vertex_index;
      for (int k = 0; k < 3; k++) send_vertex(c[k]);
   endtask

   task automatic test_directed();
      // plain right triangle with unit UV
      send_corner(32'd0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
      send_corner(32'd1, 32'h1_0000, 32'h0, 32'h0, 32'h1_0000, 32'h0);
      send_corner(32'hffff_ffff, 32'h0, 32'h1_0000, 32'h0, 32'h0, 32'h1_0000);
      // mirrored UV gives a negative determinant
      send_corner(32'd5, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
      send_corner(32'd6, 32'h0, 32'h2_0000, 32'h0, 32'h0, 32'h1_0000);
      send_corner(32'd7, 32'h0, 32'h0, 32'h3_0000, 32'h1_0000, 32'h0);
      // extreme positions and texture coordinates
      send_corner(32'h8000_0000, MinNeg, MaxPos, MinNeg, MinNeg, MaxPos);
      send_corner(32'h7fff_ffff, MaxPos, MinNeg, MaxPos, MaxPos, MinNeg);
      send_corner(32'h1234_5678, MinNeg, MinNeg, MaxPos, MaxPos, MaxPos);
      // zero determinant: all corners share one UV
      send_corner(32'd10, 32'h0, 32'h0, 32'h0, 32'h5_0000, 32'h5_0000);
      send_corner(32'd11, 32'h1_0000, 32'h0, 32'h0, 32'h5_0000, 32'h5_0000);
      send_corner(32'd12, 32'h0, 32'h1_0000, 32'h0, 32'h5_0000, 32'h5_0000);
      // zero vectors: all corners at one point
      send_corner(32'd20, 32'h3_0000, 32'h3_0000, 32'h3_0000, 32'h0, 32'h0);
      send_corner(32'd21, 32'h3_0000, 32'h3_0000, 32'h3_0000, 32'h1_0000, 32'h0);
      send_corner(32'd22, 32'h3_0000, 32'h3_0000, 32'h3_0000, 32'h0, 32'h1_0000);
      // repeated indices and tiny deltas
      send_corner(32'd9, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
      send_corner(32'd9, 32'h1, 32'hffff_ffff, 32'h0, 32'h1, 32'h0);
      send_corner(32'd9, 32'h0, 32'h1, 32'h1, 32'h0, 32'hffff_ffff);
      go_idle_until_drained();
   endtask

   task automatic test_random_phase(input int send_pct, input int recv_pct,
                                    input int triangles);
      send_idle_pct = send_pct;
      recv_stall_pct = recv_pct;
      repeat (triangles) send_random_triangle();
   endtask

   // receiver holds off while the sender keeps offering items
   task automatic test_back_pressure();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_off_req++;
      repeat (5) send_random_triangle();
      go_idle_until_drained();
   endtask

   initial begin
      int wait_cycles;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_phase(0, 0, 38);
      test_random_phase(54, 0, 36);
      test_back_pressure();
      test_random_phase(0, 54, 36);
      go_idle_until_drained();
      test_random_phase(19, 19, 36);
      // wait out the remaining results, then a margin for stray ones
      req_tvalid <= 1'b0;
      wait_cycles = 0;
      while (basis_queue.size() != 0 && wait_cycles < 200000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (DrainCycles) @(posedge clock);
      if (basis_queue.size() != 0) begin
         $error("%0d expected result items never arrived", basis_queue.size());
         error_count++;
      end
      $display("Covered %0d vertices, %0d result items (%0d degenerate),", vertex_count,
               result_count, degenerate_count);
      $display("under free flow, sender gaps, receiver stalls and a long hold-off.");
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/ttb_pkg.sv
rtl/ttb_front.sv
rtl/ttb_queue.sv
rtl/ttb_back.sv
rtl/triangle_tangent_basis_core.sv
rtl/ttb_checker.sv
test/testbench.sv
